### design/shv_pkg.sv
// ----------------------------------------------------------------------------
// shv_pkg
// Shared types and constants for the SHV stitch stream decoder.
// ----------------------------------------------------------------------------
package shv_pkg;

    localparam int MAX_COLORS_DEF        = 256;
    localparam int BANNER_BYTES_DEF      = 86;
    localparam int THREAD_TABLE_SIZE_DEF = 43;
    localparam int QUEUE_DEPTH_DEF       = 2;

    localparam logic [2:0] KIND_THREAD = 3'd0;
    localparam logic [2:0] KIND_NORMAL = 3'd1;
    localparam logic [2:0] KIND_JUMP   = 3'd2;
    localparam logic [2:0] KIND_TRIM   = 3'd3;
    localparam logic [2:0] KIND_STOP   = 3'd4;
    localparam logic [2:0] KIND_END    = 3'd5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [5:0]         thread_index;
        logic               last_of_run;
    } t_out_item;

    // Results caused by one byte: an optional stop, an optional main record, an optional end.
    typedef struct packed {
        logic               stop_v;
        logic               main_v;
        logic               end_v;
        logic [2:0]         kind;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [5:0]         thread_index;
    } t_bundle;

endpackage

### design/shv_queue.sv
// ----------------------------------------------------------------------------
// shv_queue
// Small FIFO of per-byte result bundles between the parser and the emitter.
// ----------------------------------------------------------------------------
module shv_queue #(
    parameter int DEPTH = shv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  shv_pkg::t_bundle i_data,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_valid,
    output shv_pkg::t_bundle o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    shv_pkg::t_bundle r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_ok, rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_ok) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_ok) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (wr_ok && !rd_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### design/shv_front.sv
// ----------------------------------------------------------------------------
// shv_front
// Byte parser: walks the file layout, keeps the stitch count table and
// turns each accepted byte into a bundle of up to three results.
// ----------------------------------------------------------------------------
module shv_front #(
    parameter int MAX_COLORS        = shv_pkg::MAX_COLORS_DEF,
    parameter int BANNER_BYTES      = shv_pkg::BANNER_BYTES_DEF,
    parameter int THREAD_TABLE_SIZE = shv_pkg::THREAD_TABLE_SIZE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  shv_pkg::t_in_item i_item,
    output logic             o_bundle_v,
    output shv_pkg::t_bundle  o_bundle
);
    localparam int IW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;

    localparam logic [3:0] PH_BANNER  = 4'd0;
    localparam logic [3:0] PH_NAMELEN = 4'd1;
    localparam logic [3:0] PH_NAME    = 4'd2;
    localparam logic [3:0] PH_WIDTH   = 4'd3;
    localparam logic [3:0] PH_HEIGHT  = 4'd4;
    localparam logic [3:0] PH_DIMS    = 4'd5;
    localparam logic [3:0] PH_BITMAP  = 4'd6;
    localparam logic [3:0] PH_NCOLORS = 4'd7;
    localparam logic [3:0] PH_HDR     = 4'd8;
    localparam logic [3:0] PH_COUNT   = 4'd9;
    localparam logic [3:0] PH_COLNUM  = 4'd10;
    localparam logic [3:0] PH_COLTAIL = 4'd11;
    localparam logic [3:0] PH_PAIR0   = 4'd12;
    localparam logic [3:0] PH_PAIR1   = 4'd13;
    localparam logic [3:0] PH_TRIM    = 4'd14;

    typedef logic [7:0] t_mod_tab [256];

    // Count up and wrap at the table size to get each entry's residue.
    function automatic t_mod_tab build_mod_tab(input int t);
        t_mod_tab tab;
        int       m;
        m = 0;
        for (int j = 0; j < 256; j++) begin
            tab[j] = 8'(m);
            m = (m + 1 >= t) ? 0 : m + 1;
        end
        return tab;
    endfunction

    localparam t_mod_tab MOD_TAB = build_mod_tab(THREAD_TABLE_SIZE);

    function automatic logic signed [15:0] flip(input logic signed [15:0] v);
        return (v == 16'sh8000) ? 16'sh7FFF : -v;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [1:0] k);
        logic [32:0] s;
        s = {1'b0, a} + 33'(k);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    typedef shv_pkg::t_bundle t_bundle_int;

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_skip, n_skip;
    logic [31:0] r_field, n_field;
    logic [7:0]  r_width, n_width;
    logic [7:0]  r_ctotal, n_ctotal;
    logic [7:0]  r_rcount, n_rcount;
    logic [7:0]  r_pend, n_pend;
    logic [23:0] r_trim, n_trim;
    logic        r_jump, n_jump;
    logic [31:0] r_since, n_since;
    logic [8:0]  r_active, n_active;
    logic        r_seen, n_seen;

    logic [31:0] r_count_mem [MAX_COLORS];
    logic [31:0] r_cur_count;
    logic        mem_we;

    logic [7:0]  b;
    logic [15:0] bmp_len;
    logic [31:0] base;
    t_bundle_int bun;

    assign b       = i_item.in_byte;
    assign bmp_len = 16'(({1'b0, r_field[7:0]} + 9'd1) >> 1) * 16'(r_width);

    always_comb begin
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_field  = r_field;
        n_width  = r_width;
        n_ctotal = r_ctotal;
        n_rcount = r_rcount;
        n_pend   = r_pend;
        n_trim   = r_trim;
        n_jump   = r_jump;
        n_since  = r_since;
        n_active = r_active;
        n_seen   = r_seen;
        mem_we   = 1'b0;
        base     = r_since;
        bun      = '0;

        unique case (r_phase)
            PH_BANNER, PH_NAME, PH_DIMS, PH_BITMAP, PH_HDR, PH_COLTAIL: begin
                if (r_skip > 16'd1) begin
                    n_skip = r_skip - 16'd1;
                end else begin
                    n_skip = '0;
                    priority case (r_phase)
                        PH_BANNER: n_phase = PH_NAMELEN;
                        PH_NAME:   n_phase = PH_WIDTH;
                        PH_DIMS: begin
                            if (bmp_len != '0) begin
                                n_phase = PH_BITMAP;
                                n_skip  = bmp_len;
                            end else begin
                                n_phase = PH_NCOLORS;
                            end
                        end
                        PH_BITMAP: n_phase = PH_NCOLORS;
                        default: begin
                            if (r_rcount < r_ctotal) begin
                                n_phase = PH_COUNT;
                                n_skip  = 16'd4;
                                n_field = '0;
                            end else begin
                                n_phase = PH_PAIR0;
                            end
                        end
                    endcase
                end
            end
            PH_NAMELEN: begin
                if (b != '0) begin
                    n_phase = PH_NAME;
                    n_skip  = 16'(b);
                end else begin
                    n_phase = PH_WIDTH;
                end
            end
            PH_WIDTH: begin
                n_width = b;
                n_phase = PH_HEIGHT;
            end
            PH_HEIGHT: begin
                n_field = 32'(b);
                n_phase = PH_DIMS;
                n_skip  = 16'd4;
            end
            PH_NCOLORS: begin
                n_ctotal = b;
                n_rcount = '0;
                n_phase  = PH_HDR;
                n_skip   = (b != '0) ? 16'd18 : 16'd16;
            end
            PH_COUNT: begin
                n_field = {r_field[23:0], b};
                if (r_skip > 16'd1) begin
                    n_skip = r_skip - 16'd1;
                end else begin
                    n_skip  = '0;
                    n_phase = PH_COLNUM;
                end
            end
            PH_COLNUM: begin
                mem_we           = (9'(r_rcount) < 9'(MAX_COLORS));
                bun.main_v       = 1'b1;
                bun.kind         = shv_pkg::KIND_THREAD;
                bun.thread_index = MOD_TAB[b][5:0];
                n_rcount         = r_rcount + 8'd1;
                n_phase          = PH_COLTAIL;
                n_skip           = (9'(r_rcount) + 9'd1 >= 9'(r_ctotal)) ? 16'd7 : 16'd9;
            end
            PH_PAIR0: begin
                n_pend  = b;
                n_phase = PH_PAIR1;
            end
            PH_PAIR1: begin
                n_phase = PH_PAIR0;
                if (r_active < 9'(r_ctotal) && 10'(r_active) < 10'(MAX_COLORS)
                        && r_since >= r_cur_count) begin
                    bun.stop_v = 1'b1;
                    n_seen     = 1'b1;
                    n_active   = r_active + 9'd1;
                    base       = '0;
                end
                if (r_pend == 8'h80 && (b == 8'd1 || b == 8'd2 || b == 8'd3)) begin
                    if (b == 8'd1) begin
                        n_since = sat_add(base, 2'd3);
                        n_phase = PH_TRIM;
                        n_skip  = 16'd4;
                        n_trim  = '0;
                    end else begin
                        n_since = sat_add(base, 2'd1);
                        if (b == 8'd2) begin
                            n_jump = 1'b0;
                        end
                    end
                end else begin
                    n_since    = sat_add(base, (r_pend == 8'h80) ? 2'd2 : 2'd1);
                    bun.main_v = 1'b1;
                    bun.kind   = r_jump ? shv_pkg::KIND_JUMP : shv_pkg::KIND_NORMAL;
                    bun.dx     = 16'(signed'(r_pend));
                    bun.dy     = flip(16'(signed'(b)));
                    n_seen     = 1'b1;
                end
            end
            PH_TRIM: begin
                if (r_skip > 16'd1) begin
                    n_trim = {r_trim[15:0], b};
                    n_skip = r_skip - 16'd1;
                end else begin
                    n_skip     = '0;
                    bun.main_v = 1'b1;
                    bun.kind   = shv_pkg::KIND_TRIM;
                    bun.dx     = r_trim[23:8];
                    bun.dy     = flip({r_trim[7:0], b});
                    n_seen     = 1'b1;
                    n_jump     = 1'b1;
                    n_phase    = PH_PAIR0;
                end
            end
            default: n_phase = PH_PAIR0;
        endcase

        if (i_item.end_of_file) begin
            bun.end_v = n_seen;
            n_phase  = PH_BANNER;
            n_skip   = 16'(BANNER_BYTES);
            n_field  = '0;
            n_width  = '0;
            n_ctotal = '0;
            n_rcount = '0;
            n_pend   = '0;
            n_trim   = '0;
            n_jump   = 1'b0;
            n_since  = '0;
            n_active = '0;
            n_seen   = 1'b0;
        end
    end

    assign o_bundle   = bun;
    assign o_bundle_v = i_accept && (bun.stop_v || bun.main_v || bun.end_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_BANNER;
            r_skip   <= 16'(BANNER_BYTES);
            r_field  <= '0;
            r_width  <= '0;
            r_ctotal <= '0;
            r_rcount <= '0;
            r_pend   <= '0;
            r_trim   <= '0;
            r_jump   <= 1'b0;
            r_since  <= '0;
            r_active <= '0;
            r_seen   <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_field  <= n_field;
            r_width  <= n_width;
            r_ctotal <= n_ctotal;
            r_rcount <= n_rcount;
            r_pend   <= n_pend;
            r_trim   <= n_trim;
            r_jump   <= n_jump;
            r_since  <= n_since;
            r_active <= n_active;
            r_seen   <= n_seen;
        end
    end

    // Keep the active colour's count loaded; it refreshes every cycle.
    always_ff @(posedge i_clk) begin
        if (i_accept && mem_we) begin
            r_count_mem[r_rcount[IW-1:0]] <= r_field;
        end
        r_cur_count <= r_count_mem[r_active[IW-1:0]];
    end

endmodule

### design/shv_back.sv
// ----------------------------------------------------------------------------
// shv_back
// Emitter: unpacks each result bundle into single results and holds the
// oldest one in the output register until it is popped.
// ----------------------------------------------------------------------------
module shv_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  shv_pkg::t_bundle   i_q_data,
    output logic              o_q_rd,
    output logic              o_out_v,
    output shv_pkg::t_out_item o_out,
    input  logic              i_pop
);
    shv_pkg::t_bundle   r_bun;
    logic [2:0]         r_mask, n_mask, low;
    logic               r_out_v, out_free, emit, load;
    shv_pkg::t_out_item r_out, cur;

    assign low      = r_mask & (~r_mask + 3'd1);
    assign out_free = !r_out_v || i_pop;
    assign emit     = out_free && (r_mask != '0);
    assign n_mask   = emit ? (r_mask & ~low) : r_mask;
    assign load     = (n_mask == '0) && i_q_valid;
    assign o_q_rd   = load;
    assign o_out_v  = r_out_v;
    assign o_out    = r_out;

    always_comb begin
        cur              = '0;
        cur.last_of_run  = (n_mask == '0);
        unique case (low)
            3'b001: cur.kind = shv_pkg::KIND_STOP;
            3'b010: begin
                cur.kind         = r_bun.kind;
                cur.dx           = r_bun.dx;
                cur.dy           = r_bun.dy;
                cur.thread_index = r_bun.thread_index;
            end
            3'b100: cur.kind = shv_pkg::KIND_END;
            default: cur.kind = shv_pkg::KIND_END;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (load) begin
                r_mask <= {i_q_data.end_v, i_q_data.main_v, i_q_data.stop_v};
            end else begin
                r_mask <= n_mask;
            end
            if (emit) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bun <= i_q_data;
        end
        if (emit) begin
            r_out <= cur;
        end
    end

endmodule

### design/shv_stitch_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// shv_stitch_stream_decoder_top
// SHV embroidery file decoder: bytes in, thread/stitch/trim/stop/end records out.
// ----------------------------------------------------------------------------
// Push one file byte per cycle; the parser takes a byte every cycle while
// the bundle queue has room. A byte yields zero to three records, and the
// output side hands out one record per cycle while pop is held, so sustained
// rate is one byte per cycle except where records pile up. The stitch-count
// table is a MAX_COLORS x 32 memory with no clearing pass; counts are
// written while the colour headers go by.
module shv_stitch_stream_decoder_top #(
    parameter int MAX_COLORS        = shv_pkg::MAX_COLORS_DEF,
    parameter int BANNER_BYTES      = shv_pkg::BANNER_BYTES_DEF,
    parameter int THREAD_TABLE_SIZE = shv_pkg::THREAD_TABLE_SIZE_DEF,
    parameter int QUEUE_DEPTH       = shv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  shv_pkg::t_in_item  i_item,
    output logic              empty,
    input  logic              pop,
    output shv_pkg::t_out_item o_result
);
    logic             accept, b_v, q_full, q_valid, q_rd, out_v;
    shv_pkg::t_bundle b_data, q_data;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign empty  = !out_v;

    shv_front #(
        .MAX_COLORS        (MAX_COLORS),
        .BANNER_BYTES      (BANNER_BYTES),
        .THREAD_TABLE_SIZE (THREAD_TABLE_SIZE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_bundle_v (b_v),
        .o_bundle   (b_data)
    );

    shv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (b_v),
        .i_data  (b_data),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    shv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_rd    (q_rd),
        .o_out_v   (out_v),
        .o_out     (o_result),
        .i_pop     (pop)
    );

endmodule

### verif/shv_stitch_stream_decoder_top_test.sv
// ----------------------------------------------------------------------------
// shv_stitch_stream_decoder_top_test
// Self-checking bench for the SHV stitch stream decoder.
// ----------------------------------------------------------------------------
// Whole SHV files are built byte by byte into a send queue: the header with
// its banner, name, size fields, bitmap and colour records, then a body of
// stitch pairs, escapes and trims. A behavioral decoder predicts the records
// that every accepted byte causes. Every popped record is checked against the
// oldest prediction. Sender and receiver idle in several phases.
module shv_stitch_stream_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        S_BANNER, S_NAMELEN, S_NAME, S_WIDTH, S_HEIGHT, S_DIMS, S_BITMAP,
        S_NCOLORS, S_HDR, S_COUNT, S_COLNUM, S_TAIL, S_PAIR0, S_PAIR1, S_TRIM
    } t_parse;

    localparam logic [7:0] ESC       = 8'h80;
    localparam logic [7:0] ESC_TRIM  = 8'h01;
    localparam logic [7:0] ESC_JEND  = 8'h02;
    localparam logic [7:0] ESC_SKIP  = 8'h03;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic               full, empty;
    shv_pkg::t_in_item  i_item = '0;
    shv_pkg::t_out_item o_result;

    shv_stitch_stream_decoder_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // decoder state
    t_parse      dec_phase;
    logic [15:0] dec_left;
    logic [31:0] dec_acc;
    logic [7:0]  dec_width, dec_ncol, dec_rec, dec_first;
    logic [31:0] dec_counts [256];
    logic [23:0] dec_trim;
    logic        dec_jump, dec_seen;
    logic [31:0] dec_since;
    logic [8:0]  dec_active;

    shv_pkg::t_in_item  send_q [$];
    shv_pkg::t_out_item record_q [$];
    int        total_bytes, taken, body_bytes, files, records_ok, errors, cycles, limit;

    task automatic decoder_clear();
        dec_phase = S_BANNER; dec_left = 16'(shv_pkg::BANNER_BYTES_DEF); dec_acc = '0;
        dec_width = '0; dec_ncol = '0; dec_rec = '0; dec_first = '0; dec_trim = '0;
        dec_jump = 1'b0; dec_seen = 1'b0; dec_since = '0; dec_active = '0;
    endtask

    task automatic bump_since(input int k);
        logic [32:0] s;
        s = {1'b0, dec_since} + 33'(k);
        dec_since = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endtask

    function automatic logic signed [15:0] flip_y(input int v);
        int r;
        r = -v;
        return (r > 32767) ? 16'sd32767 : 16'(r);
    endfunction

    // Work out the records caused by one byte and queue them.
    task automatic decode_byte(input shv_pkg::t_in_item it);
        shv_pkg::t_out_item recs [$];
        shv_pkg::t_out_item r;
        logic [7:0] b;
        logic [7:0] b0;
        logic       was_jump;
        int         h;
        b = it.in_byte;
        r = '0;
        case (dec_phase)
            S_BANNER, S_NAME, S_DIMS, S_BITMAP, S_HDR, S_TAIL: begin
                if (dec_left > 16'd1) begin
                    dec_left--;
                end else begin
                    dec_left = '0;
                    case (dec_phase)
                        S_BANNER: dec_phase = S_NAMELEN;
                        S_NAME:   dec_phase = S_WIDTH;
                        S_DIMS: begin
                            h = ((dec_acc[7:0] + 1) >> 1) * dec_width;
                            if (h != 0) begin
                                dec_phase = S_BITMAP; dec_left = 16'(h);
                            end else begin
                                dec_phase = S_NCOLORS;
                            end
                        end
                        S_BITMAP: dec_phase = S_NCOLORS;
                        default: begin
                            if (dec_rec < dec_ncol) begin
                                dec_phase = S_COUNT; dec_left = 16'd4; dec_acc = '0;
                            end else begin
                                dec_phase = S_PAIR0;
                            end
                        end
                    endcase
                end
            end
            S_NAMELEN: begin
                if (b != 0) begin
                    dec_phase = S_NAME; dec_left = 16'(b);
                end else begin
                    dec_phase = S_WIDTH;
                end
            end
            S_WIDTH: begin
                dec_width = b; dec_phase = S_HEIGHT;
            end
            S_HEIGHT: begin
                dec_acc = 32'(b); dec_phase = S_DIMS; dec_left = 16'd4;
            end
            S_NCOLORS: begin
                dec_ncol = b; dec_rec = '0; dec_phase = S_HDR;
                dec_left = (b != 0) ? 16'd18 : 16'd16;
            end
            S_COUNT: begin
                dec_acc = {dec_acc[23:0], b};
                if (dec_left > 16'd1) dec_left--;
                else begin
                    dec_left = '0; dec_phase = S_COLNUM;
                end
            end
            S_COLNUM: begin
                dec_counts[dec_rec] = dec_acc;
                r.kind = shv_pkg::KIND_THREAD;
                r.thread_index = 6'(b % shv_pkg::THREAD_TABLE_SIZE_DEF);
                recs.push_back(r);
                dec_rec++;
                dec_phase = S_TAIL;
                dec_left = (dec_rec >= dec_ncol) ? 16'd7 : 16'd9;
            end
            S_PAIR0: begin
                dec_first = b; dec_phase = S_PAIR1;
            end
            S_PAIR1: begin
                b0 = dec_first;
                was_jump = dec_jump;
                dec_phase = S_PAIR0;
                if (dec_active < 9'(dec_ncol) && dec_since >= dec_counts[dec_active[7:0]]) begin
                    r = '0; r.kind = shv_pkg::KIND_STOP; recs.push_back(r);
                    dec_seen = 1'b1; dec_active++; dec_since = '0;
                end
                if (b0 == ESC && (b == ESC_TRIM || b == ESC_JEND || b == ESC_SKIP)) begin
                    bump_since(1);
                    if (b == ESC_JEND) dec_jump = 1'b0;
                    else if (b == ESC_TRIM) begin
                        bump_since(2);
                        dec_phase = S_TRIM; dec_left = 16'd4; dec_trim = '0;
                    end
                end else begin
                    if (b0 == ESC) bump_since(1);
                    bump_since(1);
                    r = '0;
                    r.kind = was_jump ? shv_pkg::KIND_JUMP : shv_pkg::KIND_NORMAL;
                    r.dx = 16'(signed'(b0));
                    r.dy = flip_y(int'(signed'(b)));
                    recs.push_back(r);
                    dec_seen = 1'b1;
                end
            end
            default: begin  // trim offsets
                if (dec_left > 16'd1) begin
                    dec_trim = {dec_trim[15:0], b}; dec_left--;
                end else begin
                    dec_left = '0;
                    r = '0; r.kind = shv_pkg::KIND_TRIM;
                    r.dx = signed'(dec_trim[23:8]);
                    r.dy = flip_y(int'(signed'({dec_trim[7:0], b})));
                    recs.push_back(r);
                    dec_seen = 1'b1; dec_jump = 1'b1; dec_phase = S_PAIR0;
                end
            end
        endcase
        if (it.end_of_file) begin
            if (dec_seen) begin
                r = '0; r.kind = shv_pkg::KIND_END; recs.push_back(r);
            end
            decoder_clear();
        end
        if (recs.size() > 0) recs[recs.size() - 1].last_of_run = 1'b1;
        foreach (recs[k]) record_q.push_back(recs[k]);
    endtask

    // stimulus building
    task automatic put_byte(input logic [7:0] b, input bit counts = 1'b0);
        shv_pkg::t_in_item it;
        it.in_byte = b; it.end_of_file = 1'b0;
        send_q.push_back(it);
        if (counts) body_bytes++;
    endtask

    task automatic put_header(input int ncol, input int w, input int h, input int cnt_max);
        int namelen;
        logic [31:0] cnt;
        namelen = $urandom_range(0, 5);
        repeat (shv_pkg::BANNER_BYTES_DEF) put_byte(8'($urandom));
        put_byte(8'(namelen));
        repeat (namelen) put_byte(8'($urandom));
        put_byte(8'(w)); put_byte(8'(h));
        repeat (4) put_byte(8'($urandom));
        repeat (((h + 1) / 2) * w) put_byte(8'($urandom));
        put_byte(8'(ncol));
        repeat ((ncol != 0) ? 18 : 16) put_byte(8'($urandom));
        for (int c = 0; c < ncol; c++) begin
            cnt = ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, cnt_max);
            for (int k = 3; k >= 0; k--) put_byte(cnt[8*k +: 8]);
            put_byte(8'($urandom));
            repeat ((c == ncol - 1) ? 7 : 9) put_byte(8'($urandom));
        end
    endtask

    // Random pair mix: mostly plain stitches, with escapes and trims.
    task automatic put_body(input int npairs);
        int sel;
        repeat (npairs) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                put_byte(8'($urandom), 1'b1); put_byte(8'($urandom), 1'b1);
            end else if (sel < 70) begin
                put_byte(ESC, 1'b1); put_byte(ESC_JEND, 1'b1);
            end else if (sel < 77) begin
                put_byte(ESC, 1'b1); put_byte(ESC_SKIP, 1'b1);
            end else if (sel < 85) begin
                put_byte(ESC, 1'b1); put_byte(8'($urandom), 1'b1);
            end else begin
                put_byte(ESC, 1'b1); put_byte(ESC_TRIM, 1'b1);
                repeat (4) put_byte(($urandom_range(0, 3) == 0) ? 8'h80 : 8'($urandom), 1'b1);
            end
        end
    endtask

    task automatic close_file();
        send_q[send_q.size() - 1].end_of_file = 1'b1;
        files++;
    endtask

    // driver
    int send_mode, send_idle, recv_idle;
    always @(negedge i_clk) begin
        send_mode = (total_bytes == 0) ? 0 : (taken * 4) / total_bytes;
        send_idle = (send_mode == 1 || send_mode == 3) ? 46 : (send_mode == 2 ? 0 : 0);
        if (send_mode == 3) send_idle = 37;
        recv_idle = (send_mode == 2) ? 46 : (send_mode == 3 ? 37 : 0);
        if (i_rst_n && send_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
            push <= 1'b1;
            i_item <= send_q[0];
        end else begin
            push <= 1'b0;
        end
        pop <= ($urandom_range(0, 99) >= recv_idle);
    end

    // acceptance and checking
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            decode_byte(i_item);
            void'(send_q.pop_front());
            taken++;
        end
        if (i_rst_n && pop && !empty) begin
            if (record_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected record: %p", o_result);
            end else if (o_result !== record_q[0]) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected kind %0d dx %0d dy %0d ti %0d last %0b,",
                              " got kind %0d dx %0d dy %0d ti %0d last %0b"},
                        record_q[0].kind, record_q[0].dx, record_q[0].dy,
                        record_q[0].thread_index, record_q[0].last_of_run,
                        o_result.kind, o_result.dx, o_result.dy,
                        o_result.thread_index, o_result.last_of_run);
                void'(record_q.pop_front());
            end else begin
                records_ok++;
                void'(record_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (limit > 0 && cycles > limit) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        decoder_clear();
        // extremes: no colours, trim with most negative offsets, odd tail byte
        put_header(0, 2, 1, 0);
        put_byte(8'h7F, 1'b1); put_byte(8'h80, 1'b1);
        put_byte(8'h80, 1'b1); put_byte(8'h00, 1'b1);
        put_byte(8'h80, 1'b1); put_byte(8'hFF, 1'b1);
        put_byte(ESC, 1'b1); put_byte(ESC_TRIM, 1'b1);
        put_byte(8'h80, 1'b1); put_byte(8'h00, 1'b1);
        put_byte(8'h80, 1'b1); put_byte(8'h00, 1'b1);
        put_byte(8'h01, 1'b1); put_byte(8'h7F, 1'b1);
        put_byte(ESC, 1'b1); put_byte(ESC_JEND, 1'b1);
        put_byte(ESC, 1'b1); put_byte(ESC_SKIP, 1'b1);
        put_byte(8'h55, 1'b1);          // trailing odd byte
        close_file();
        // small counts give stops until the colours run out, then a cut trim
        put_header(2, 3, 0, 1);
        while (send_q.size() < 335) put_body(1);
        put_byte(ESC, 1'b1); put_byte(ESC_TRIM, 1'b1); put_byte(8'h12, 1'b1);
        close_file();
        // end of file inside the header
        repeat ($urandom_range(20, 40)) put_byte(8'($urandom));
        close_file();
        total_bytes = send_q.size();
        limit = total_bytes * 40 + 20000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (send_q.size() > 0 || record_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("decoded %0d files, %0d bytes (%0d in stitch bodies), %0d records matched",
            files, total_bytes, body_bytes, records_ok);
        if (errors == 0 && record_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAILURE");
        end
        $finish;
    end
endmodule

### shv_stitch_stream_decoder_top.f
design/shv_pkg.sv
design/shv_queue.sv
design/shv_front.sv
design/shv_back.sv
design/shv_stitch_stream_decoder_top.sv
verif/shv_stitch_stream_decoder_top_test.sv
